FILE: hdl/assert_macros.svh
// Assertion macros shared by the waveform angle RTL.
// Needs nothing else; files that check their own logic include it by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check that is switched off while the reset is held.
`define PWA_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: check failed");
// Check that also holds while the reset is held.
`define PWA_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("%m: check failed");
`else
`define PWA_ASSERT(lbl, clk, rst_n, prop)
`define PWA_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

FILE: hdl/pwa_pkg.sv
// Shared widths, register indexes, shape mode codes and Q1.15 levels.
// Depends on nothing; used by the waveform angle core.
`default_nettype none

package pwa_pkg;

    localparam int TIME_W     = 32;
    localparam int PERIOD_W   = 24;
    localparam int FRAC_W     = 10;
    localparam int CFG_ANG_W  = 17;
    localparam int ANGLE_W    = 18;
    localparam int SHAPE_W    = 16;
    localparam int MODE_W     = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;
    localparam int RAMP_BITS  = 16;
    localparam int SINE_W     = 15;

    localparam logic [FRAC_W-1:0] FRAC_FULL = 10'd1000;

    localparam logic signed [SHAPE_W-1:0] Q15_POS = 16'sh7fff;
    localparam logic signed [SHAPE_W-1:0] Q15_NEG = 16'sh8000;
    localparam logic signed [SHAPE_W-1:0] Q15_ZERO = 16'sh0000;

    // pi/2 in Q30 for the quarter-wave table
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    localparam logic [MODE_W-1:0] MODE_SINE   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SQUARE = 3'd1;
    localparam logic [MODE_W-1:0] MODE_TRI    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_SAW    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_TRAP   = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_SHAPE_MODE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DUTY       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RISE       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_FALL       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE  = 3'd7;

endpackage

`default_nettype wire

FILE: hdl/pwa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing; holds the sine quarter-wave table of the core.
`default_nettype none

module pwa_ram #(
    parameter int WIDTH = 15,
    parameter int DEPTH = 1025
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: hdl/pwa_div_cell.sv
// One cell of a restoring divider chain: one quotient bit per cell.
// Depends on assert_macros.svh; instantiated in rows by the core.
`default_nettype none
`include "assert_macros.svh"

module pwa_div_cell #(
    parameter int REM_W  = 24,
    parameter int WORD_W = 48
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [REM_W-1:0]  i_rem,
    input  wire logic [REM_W-1:0]  i_div,
    input  wire logic [WORD_W-1:0] i_word,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic      [REM_W-1:0]  o_rem,
    output logic      [REM_W-1:0]  o_div,
    output logic      [WORD_W-1:0] o_word
);

    logic              r_valid;
    logic [REM_W-1:0]  r_rem;
    logic [REM_W-1:0]  r_div;
    logic [WORD_W-1:0] r_word;
    logic [REM_W-1:0]  n_rem;
    logic [WORD_W-1:0] n_word;
    logic [REM_W:0]    trial;
    logic [REM_W:0]    diff;
    logic              take;
    logic              load;

    // The word shifts its top bit into the remainder and takes the
    // quotient bit in at the bottom.
    always_comb begin
        trial  = {i_rem, i_word[WORD_W-1]};
        diff   = trial - {1'b0, i_div};
        take   = (trial >= {1'b0, i_div});
        n_rem  = take ? diff[REM_W-1:0] : trial[REM_W-1:0];
        n_word = {i_word[WORD_W-2:0], take};
    end

    assign load    = !r_valid || i_ready;
    assign o_ready = load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= i_valid;
        end
        if (load && i_valid) begin
            r_rem  <= n_rem;
            r_div  <= i_div;
            r_word <= n_word;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_div   = r_div;
    assign o_word  = r_word;

    `PWA_ASSERT(a_cell_hold, i_clk, i_rst_n, (r_valid && !i_ready) |=> (r_valid && $stable(r_word)))
    `PWA_ASSERT(a_cell_div_nz, i_clk, i_rst_n, r_valid |-> (r_div != '0))

endmodule

`default_nettype wire

FILE: hdl/periodic_waveform_angle_core.sv
// Top level of the periodic waveform angle core: time in, servo angle out.
// Depends on pwa_pkg, pwa_div_cell, pwa_ram and assert_macros.svh.
//
// Usage. Each input beat carries a millisecond time on i_time_ms and each
// output beat carries one angle in centidegrees on o_angle_centideg. Both
// channels move a beat when valid is high and stall is low. Settings are
// written through the configuration channel (i_cfg_index selects the
// register, i_cfg_data holds the value); it is always ready, and it must
// be used only while no beat is in flight; the block does not check.
// A row of 32 + PHASE_BITS divider cells forms the phase, two stages shape
// it, a row of 16 divider cells forms the trapezoid ramp, and three stages
// read the sine table, multiply by the amplitude and add the offset.
// Throughput is one beat per cycle unless stalled: every cell and stage
// advances on its own, so a bubble is squeezed out when the output stalls.
// After reset the sine table is swept into the RAM, filling all of its
// SINE_TABLE_DEPTH + 1 entries (1025 by default); o_stall is high until it
// is finished. A stall on the output holds the last beat in the output
// register and backs up through the rows until o_stall rises.
`default_nettype none
`include "assert_macros.svh"

module periodic_waveform_angle_core #(
    parameter int SINE_TABLE_DEPTH = 1024,
    parameter int PHASE_BITS       = 16
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_valid,
    output logic                                      o_stall,
    input  wire logic        [pwa_pkg::TIME_W-1:0]    i_time_ms,
    output logic                                      o_valid,
    input  wire logic                                 i_stall,
    output logic signed      [pwa_pkg::ANGLE_W-1:0]   o_angle_centideg,
    input  wire logic                                 i_cfg_valid,
    output logic                                      o_cfg_ready,
    input  wire logic        [pwa_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic        [pwa_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int PB     = PHASE_BITS;
    localparam int AW     = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int NA     = pwa_pkg::TIME_W + PB;
    localparam int NB     = pwa_pkg::RAMP_BITS;
    localparam int PW     = pwa_pkg::PERIOD_W;
    localparam int FW     = pwa_pkg::FRAC_W;
    localparam int SW     = pwa_pkg::SHAPE_W;
    localparam int DB_W   = FW + PB;
    localparam int PD_W   = PB + 12;
    localparam int SQ_W   = PB + FW;
    localparam int JM_W   = PB - 2 + AW;
    localparam int PROD_W = pwa_pkg::CFG_ANG_W + SW;

    typedef enum logic [1:0] {SEL_VAL, SEL_SINE, SEL_RISE, SEL_FALL} t_sel;

    typedef struct packed {
        t_sel                   sel;
        logic                   neg;
        logic [AW-1:0]          addr;
        logic signed [SW-1:0]   s_val;
    } t_sb;

    // Quarter-wave sine entry in Q1.15, Taylor series in Q30 to x^19.
    function automatic logic [pwa_pkg::SINE_W-1:0] sine_entry(input int idx);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic [63:0]        q15;
        x    = (pwa_pkg::HALF_PI_Q30 * 64'(idx) + 64'(SINE_TABLE_DEPTH / 2))
               / 64'(SINE_TABLE_DEPTH);
        x2   = (x * x) >> 30;
        term = x;
        sum  = $signed(x);
        for (int k = 1; k <= 9; k++) begin
            term = ((term * x2) >> 30) / 64'((2 * k) * (2 * k + 1));
            if ((k % 2) == 1) begin
                sum = sum - $signed(term);
            end else begin
                sum = sum + $signed(term);
            end
        end
        if (sum < 0) begin
            sum = '0;
        end
        q15 = (64'(sum) + 64'd16384) >> 15;
        if (q15 > 64'd32767) begin
            q15 = 64'd32767;
        end
        return q15[pwa_pkg::SINE_W-1:0];
    endfunction

    // Configuration registers.
    logic [pwa_pkg::MODE_W-1:0]           r_mode;
    logic [PW-1:0]                        r_period;
    logic [FW-1:0]                        r_duty;
    logic [FW-1:0]                        r_rise;
    logic [FW-1:0]                        r_hold;
    logic [FW-1:0]                        r_fall;
    logic signed [pwa_pkg::CFG_ANG_W-1:0] r_offset;
    logic signed [pwa_pkg::CFG_ANG_W-1:0] r_amp;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= pwa_pkg::MODE_SINE;
            r_period <= 24'd1000;
            r_duty   <= 10'd500;
            r_rise   <= 10'd250;
            r_hold   <= 10'd250;
            r_fall   <= 10'd250;
            r_offset <= 17'sd9000;
            r_amp    <= 17'sd4500;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                pwa_pkg::CFG_SHAPE_MODE: r_mode   <= i_cfg_data[pwa_pkg::MODE_W-1:0];
                pwa_pkg::CFG_PERIOD:     r_period <= i_cfg_data[PW-1:0];
                pwa_pkg::CFG_DUTY:       r_duty   <= i_cfg_data[FW-1:0];
                pwa_pkg::CFG_RISE:       r_rise   <= i_cfg_data[FW-1:0];
                pwa_pkg::CFG_HOLD:       r_hold   <= i_cfg_data[FW-1:0];
                pwa_pkg::CFG_FALL:       r_fall   <= i_cfg_data[FW-1:0];
                pwa_pkg::CFG_OFFSET:     r_offset <= $signed(i_cfg_data[pwa_pkg::CFG_ANG_W-1:0]);
                pwa_pkg::CFG_AMPLITUDE:  r_amp    <= $signed(i_cfg_data[pwa_pkg::CFG_ANG_W-1:0]);
                default: ;
            endcase
        end
    end

    // Settings as the datapath sees them: a zero period counts as one,
    // fractions above 100 % clamp, and an oversized trapezoid is scaled
    // to the sum of its segments.
    logic [PW-1:0] p_eff;
    logic [FW-1:0] duty_c;
    logic [FW-1:0] rise_c;
    logic [FW-1:0] hold_c;
    logic [FW-1:0] fall_c;
    logic [11:0]   d_sum;
    logic [11:0]   d_eff;

    always_comb begin
        p_eff  = (r_period == '0) ? PW'(1) : r_period;
        duty_c = (r_duty > pwa_pkg::FRAC_FULL) ? pwa_pkg::FRAC_FULL : r_duty;
        rise_c = (r_rise > pwa_pkg::FRAC_FULL) ? pwa_pkg::FRAC_FULL : r_rise;
        hold_c = (r_hold > pwa_pkg::FRAC_FULL) ? pwa_pkg::FRAC_FULL : r_hold;
        fall_c = (r_fall > pwa_pkg::FRAC_FULL) ? pwa_pkg::FRAC_FULL : r_fall;
        d_sum  = 12'(rise_c) + 12'(hold_c) + 12'(fall_c);
        d_eff  = (d_sum < 12'(pwa_pkg::FRAC_FULL)) ? 12'(pwa_pkg::FRAC_FULL) : d_sum;
    end

    // Sine table sweep after reset.
    logic [pwa_pkg::SINE_W-1:0] w_sine_rom [SINE_TABLE_DEPTH + 1];
    logic                       r_fill_busy;
    logic [AW-1:0]              r_fill_addr;

    for (genvar g = 0; g <= SINE_TABLE_DEPTH; g++) begin : g_rom
        assign w_sine_rom[g] = sine_entry(g);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill_busy <= 1'b1;
            r_fill_addr <= '0;
        end else if (r_fill_busy) begin
            if (r_fill_addr == AW'(SINE_TABLE_DEPTH)) begin
                r_fill_busy <= 1'b0;
            end else begin
                r_fill_addr <= r_fill_addr + AW'(1);
            end
        end
    end

    // Stage ready signals, from the output backwards.
    logic load1;
    logic load2;
    logic load3;
    logic load4;
    logic load5;

    // Phase divider row: (time << PB) / period, low PB quotient bits.
    logic          a_valid [NA+1];
    logic          a_rdy   [NA+1];
    logic [PW-1:0] a_rem   [NA+1];
    logic [PW-1:0] a_div   [NA+1];
    logic [NA-1:0] a_word  [NA+1];

    assign a_valid[0] = i_valid && !r_fill_busy;
    assign a_rem[0]   = '0;
    assign a_div[0]   = p_eff;
    assign a_word[0]  = {i_time_ms, {PB{1'b0}}};
    assign a_rdy[NA]  = load1;
    assign o_stall    = !a_rdy[0] || r_fill_busy;

    for (genvar k = 0; k < NA; k++) begin : g_row_a
        pwa_div_cell #(.REM_W(PW), .WORD_W(NA)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (a_valid[k]),
            .o_ready (a_rdy[k]),
            .i_rem   (a_rem[k]),
            .i_div   (a_div[k]),
            .i_word  (a_word[k]),
            .o_valid (a_valid[k+1]),
            .i_ready (a_rdy[k+1]),
            .o_rem   (a_rem[k+1]),
            .o_div   (a_div[k+1]),
            .o_word  (a_word[k+1])
        );
    end

    // Stage 1: trapezoid position and the square wave compare.
    logic            r1_valid;
    logic [PB-1:0]   r1_ph;
    logic [PD_W-1:0] r1_pd;
    logic            r1_sq;
    logic [PB-1:0]   ph_a;
    logic [SQ_W-1:0] sq_lhs;

    assign ph_a   = a_word[NA][PB-1:0];
    assign sq_lhs = SQ_W'(ph_a) * SQ_W'(pwa_pkg::FRAC_FULL);
    assign load1  = !r1_valid || load2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (load1) begin
            r1_valid <= a_valid[NA];
        end
        if (load1 && a_valid[NA]) begin
            r1_ph <= ph_a;
            r1_pd <= PD_W'(ph_a) * PD_W'(d_eff);
            r1_sq <= (sq_lhs < {duty_c, {PB{1'b0}}});
        end
    end

    // Stage 2: shape value (table address and sign for the sine) for all modes
    // but the trapezoid ramps, which go on to the ramp divider with their dividend and divisor.
    logic            r2_valid;
    t_sb             r2_sb;
    logic [DB_W-1:0] r2_x;
    logic [DB_W-1:0] r2_div;
    t_sb             n2_sb;
    logic [DB_W-1:0] n2_x;
    logic [DB_W-1:0] n2_div;
    logic [1:0]      quad;
    logic [JM_W-1:0] j_full;
    logic [AW-1:0]   j_idx;
    logic [PB+16:0]  tri_full;
    logic [PB+15:0]  saw_full;
    logic [18:0]     tri_v;
    logic signed [18:0] tri_s;
    logic [PD_W-1:0] b1;
    logic [PD_W-1:0] b2;
    logic [PD_W-1:0] b3;
    logic [PD_W-1:0] fall_x;
    logic            b_rdy0;

    always_comb begin
        quad     = r1_ph[PB-1:PB-2];
        j_full   = JM_W'(r1_ph[PB-3:0]) * JM_W'(SINE_TABLE_DEPTH);
        j_idx    = j_full[JM_W-1:PB-2];
        tri_full = {r1_ph, 17'b0} >> PB;
        saw_full = {r1_ph, 16'b0} >> PB;
        tri_v    = {2'b00, tri_full[16:0]};
        if (!r1_ph[PB-1]) begin
            tri_s = $signed(tri_v) - 19'sd32768;
        end else begin
            tri_s = 19'sd98304 - $signed(tri_v);
        end
        if (tri_s > 19'sd32767) begin
            tri_s = 19'sd32767;
        end
        b1     = PD_W'({rise_c, {PB{1'b0}}});
        b2     = PD_W'({11'(rise_c) + 11'(hold_c), {PB{1'b0}}});
        b3     = PD_W'({d_sum, {PB{1'b0}}});
        fall_x = r1_pd - b2;

        n2_sb       = '0;
        n2_sb.sel   = SEL_VAL;
        n2_sb.s_val = pwa_pkg::Q15_ZERO;
        n2_x        = '0;
        n2_div      = DB_W'(1);
        unique case (r_mode)
            pwa_pkg::MODE_SINE: begin
                n2_sb.sel  = SEL_SINE;
                n2_sb.neg  = quad[1];
                n2_sb.addr = quad[0] ? (AW'(SINE_TABLE_DEPTH) - j_idx) : j_idx;
            end
            pwa_pkg::MODE_SQUARE: begin
                n2_sb.s_val = r1_sq ? pwa_pkg::Q15_POS : pwa_pkg::Q15_NEG;
            end
            pwa_pkg::MODE_TRI: begin
                n2_sb.s_val = tri_s[SW-1:0];
            end
            pwa_pkg::MODE_SAW: begin
                // Adding -32768 to a 16-bit ramp flips its top bit.
                n2_sb.s_val = $signed({~saw_full[15], saw_full[14:0]});
            end
            pwa_pkg::MODE_TRAP: begin
                if (r1_pd < b1) begin
                    n2_sb.sel = SEL_RISE;
                    n2_x      = r1_pd[DB_W-1:0];
                    n2_div    = {rise_c, {PB{1'b0}}};
                end else if (r1_pd < b2) begin
                    n2_sb.s_val = pwa_pkg::Q15_POS;
                end else if (r1_pd < b3) begin
                    n2_sb.sel = SEL_FALL;
                    n2_x      = fall_x[DB_W-1:0];
                    n2_div    = {fall_c, {PB{1'b0}}};
                end else begin
                    n2_sb.s_val = pwa_pkg::Q15_NEG;
                end
            end
            default: ;
        endcase
    end

    assign load2 = !r2_valid || b_rdy0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (load2) begin
            r2_valid <= r1_valid;
        end
        if (load2 && r1_valid) begin
            r2_sb  <= n2_sb;
            r2_x   <= n2_x;
            r2_div <= n2_div;
        end
    end

    // Ramp divider row: (x << 16) / segment length; the side data for the
    // shape travels in a tap line beside the cells.
    logic            b_valid [NB+1];
    logic            b_rdy   [NB+1];
    logic [DB_W-1:0] b_rem   [NB+1];
    logic [DB_W-1:0] b_div   [NB+1];
    logic [NB-1:0]   b_word  [NB+1];
    t_sb             r_sb    [NB];

    assign b_valid[0] = r2_valid;
    assign b_rem[0]   = r2_x;
    assign b_div[0]   = r2_div;
    assign b_word[0]  = '0;
    assign b_rdy0     = b_rdy[0];
    assign b_rdy[NB]  = load3;

    for (genvar k = 0; k < NB; k++) begin : g_row_b
        pwa_div_cell #(.REM_W(DB_W), .WORD_W(NB)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (b_valid[k]),
            .o_ready (b_rdy[k]),
            .i_rem   (b_rem[k]),
            .i_div   (b_div[k]),
            .i_word  (b_word[k]),
            .o_valid (b_valid[k+1]),
            .i_ready (b_rdy[k+1]),
            .o_rem   (b_rem[k+1]),
            .o_div   (b_div[k+1]),
            .o_word  (b_word[k+1])
        );
    end

    // Each tap moves together with the cell beside it.
    always_ff @(posedge i_clk) begin
        if (b_rdy[0] && b_valid[0]) begin
            r_sb[0] <= r2_sb;
        end
        for (int k = 1; k < NB; k++) begin
            if (b_rdy[k] && b_valid[k]) begin
                r_sb[k] <= r_sb[k-1];
            end
        end
    end

    // Stage 3: trapezoid ramp levels and the sine table read.
    logic                       r3_valid;
    logic                       r3_sine;
    logic                       r3_neg;
    logic signed [SW-1:0]       r3_s;
    logic signed [SW-1:0]       n3_s;
    logic signed [SW:0]         ramp_up;
    logic signed [SW:0]         ramp_dn;
    logic                       ram_re;
    logic [pwa_pkg::SINE_W-1:0] rom_q;
    t_sb                        sb_b;

    assign sb_b = r_sb[NB-1];

    always_comb begin
        ramp_up = $signed({1'b0, b_word[NB]}) - 17'sd32768;
        ramp_dn = 17'sd32768 - $signed({1'b0, b_word[NB]});
        case (sb_b.sel)
            SEL_RISE: n3_s = ramp_up[SW-1:0];
            SEL_FALL: n3_s = (ramp_dn > 17'sd32767) ? pwa_pkg::Q15_POS : ramp_dn[SW-1:0];
            default:  n3_s = sb_b.s_val;
        endcase
    end

    assign load3  = !r3_valid || load4;
    assign ram_re = load3 && b_valid[NB];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (load3) begin
            r3_valid <= b_valid[NB];
        end
        if (ram_re) begin
            r3_sine <= (sb_b.sel == SEL_SINE);
            r3_neg  <= sb_b.neg;
            r3_s    <= n3_s;
        end
    end

    pwa_ram #(.WIDTH(pwa_pkg::SINE_W), .DEPTH(SINE_TABLE_DEPTH + 1)) u_sine_ram (
        .i_clk   (i_clk),
        .i_we    (r_fill_busy),
        .i_waddr (r_fill_addr),
        .i_wdata (w_sine_rom[r_fill_addr]),
        .i_re    (ram_re),
        .i_raddr (sb_b.addr),
        .o_rdata (rom_q)
    );

    // Stage 4: amplitude times shape.
    logic                     r4_valid;
    logic signed [PROD_W-1:0] r4_prod;
    logic signed [SW-1:0]     s_fin;
    logic signed [SW-1:0]     sine_s;

    assign sine_s = $signed({1'b0, rom_q});
    assign s_fin  = r3_sine ? (r3_neg ? -sine_s : sine_s) : r3_s;
    assign load4  = !r4_valid || load5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_valid <= 1'b0;
        end else if (load4) begin
            r4_valid <= r3_valid;
        end
        if (load4 && r3_valid) begin
            r4_prod <= PROD_W'(r_amp) * PROD_W'(s_fin);
        end
    end

    // Stage 5: round half up, add the offset, saturate to the port width.
    logic                                r5_valid;
    logic signed [pwa_pkg::ANGLE_W-1:0]  r5_angle;
    logic signed [pwa_pkg::ANGLE_W-1:0]  n5_angle;
    logic signed [PROD_W-1:0]            rsum;
    logic signed [pwa_pkg::ANGLE_W-1:0]  rnd;
    logic signed [pwa_pkg::ANGLE_W:0]    asum;

    always_comb begin
        rsum = r4_prod + PROD_W'(16384);
        rnd  = rsum[PROD_W-1:15];
        asum = (pwa_pkg::ANGLE_W + 1)'(r_offset) + (pwa_pkg::ANGLE_W + 1)'(rnd);
        if (asum > 19'sd131071) begin
            n5_angle = 18'sd131071;
        end else if (asum < -19'sd131072) begin
            n5_angle = -18'sd131072;
        end else begin
            n5_angle = asum[pwa_pkg::ANGLE_W-1:0];
        end
    end

    assign load5 = !r5_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_valid <= 1'b0;
        end else if (load5) begin
            r5_valid <= r4_valid;
        end
        if (load5 && r4_valid) begin
            r5_angle <= n5_angle;
        end
    end

    assign o_valid          = r5_valid;
    assign o_angle_centideg = r5_angle;

    `PWA_ASSERT_ALWAYS(a_reset_sweep, i_clk, !i_rst_n |=> (r_fill_busy && r_fill_addr == '0))
    `PWA_ASSERT(a_sweep_once, i_clk, i_rst_n, !r_fill_busy |=> !r_fill_busy)
    `PWA_ASSERT(a_read_after_fill, i_clk, i_rst_n, ram_re |-> !r_fill_busy)
    `PWA_ASSERT(a_phase_rem, i_clk, i_rst_n, a_valid[NA] |-> (a_rem[NA] < a_div[NA]))
    `PWA_ASSERT(a_ramp_rem, i_clk, i_rst_n, b_valid[NB] |-> (b_rem[NB] < b_div[NB]))

endmodule

`default_nettype wire

FILE: sim/tb_periodic_waveform_angle_core.sv
// Self-checking testbench for periodic_waveform_angle_core: time beats in, angle beats out.
// Depends on pwa_pkg and the core RTL; holds its own angle predictor in a scoreboard class.
`timescale 1ns / 100ps
`default_nettype none

module tb_periodic_waveform_angle_core;
    import pwa_pkg::*;

    localparam int TABLE_DEPTH = 1024;
    localparam int PH_BITS     = 16;
    localparam int RAND_ITEMS  = 550;

    // Scoreboard: keeps a copy of the registers, predicts the angle for every
    // accepted time beat and checks output beats against the oldest prediction.
    class angle_scoreboard;
        longint quarter_sine[TABLE_DEPTH+1];
        int unsigned mode_r, period_r, duty_r, rise_r, hold_r, fall_r;
        int offset_r, amp_r;
        logic signed [ANGLE_W-1:0] expected_angles[$];
        int mismatches;
        int checked;

        function new();
            longint x, x2, term, sum, q15;
            mode_r = MODE_SINE; period_r = 1000; duty_r = 500;
            rise_r = 250; hold_r = 250; fall_r = 250;
            offset_r = 9000; amp_r = 4500;
            mismatches = 0; checked = 0;
            for (int i = 0; i <= TABLE_DEPTH; i++) begin
                x = (longint'(HALF_PI_Q30) * i + TABLE_DEPTH / 2) / TABLE_DEPTH;
                x2 = (x * x) >>> 30;
                term = x;
                sum = x;
                for (int k = 1; k <= 9; k++) begin
                    term = ((term * x2) >>> 30) / ((2 * k) * (2 * k + 1));
                    if (k % 2 == 1) sum -= term;
                    else sum += term;
                end
                if (sum < 0) sum = 0;
                q15 = (sum + (1 << 14)) >>> 15;
                quarter_sine[i] = (q15 > 32767) ? 32767 : q15;
            end
        endfunction

        function int sext17(logic [CFG_DATA_W-1:0] d);
            logic signed [CFG_ANG_W-1:0] v;
            v = d[CFG_ANG_W-1:0];
            return int'(v);
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
            case (idx)
                CFG_SHAPE_MODE: mode_r   = d[MODE_W-1:0];
                CFG_PERIOD:     period_r = d[PERIOD_W-1:0];
                CFG_DUTY:       duty_r   = d[FRAC_W-1:0];
                CFG_RISE:       rise_r   = d[FRAC_W-1:0];
                CFG_HOLD:       hold_r   = d[FRAC_W-1:0];
                CFG_FALL:       fall_r   = d[FRAC_W-1:0];
                CFG_OFFSET:     offset_r = sext17(d);
                CFG_AMPLITUDE:  amp_r    = sext17(d);
                default: ;
            endcase
        endfunction

        function longint clamp_frac(int unsigned v);
            return (v > 1000) ? 1000 : v;
        endfunction

        function longint cap_high(longint v);
            return (v > 32767) ? 32767 : v;
        endfunction

        function longint sine_level(longint ph);
            longint quad, j, v;
            quad = (ph >> (PH_BITS - 2)) & 3;
            j = ((ph & ((1 << (PH_BITS - 2)) - 1)) * TABLE_DEPTH) >> (PH_BITS - 2);
            if (j > TABLE_DEPTH) j = TABLE_DEPTH;
            v = (quad & 1) ? quarter_sine[TABLE_DEPTH - j] : quarter_sine[j];
            return (quad & 2) ? -v : v;
        endfunction

        function longint trapezoid_level(longint ph);
            longint r, h, f, d, one, pd;
            r = clamp_frac(rise_r);
            h = clamp_frac(hold_r);
            f = clamp_frac(fall_r);
            d = r + h + f;
            one = longint'(1) << PH_BITS;
            if (d < 1000) d = 1000;
            pd = ph * d;
            if (pd < r * one) return -32768 + (65536 * pd) / (r * one);
            if (pd < (r + h) * one) return 32767;
            if (pd < (r + h + f) * one)
                return cap_high(32768 - (65536 * (pd - (r + h) * one)) / (f * one));
            return -32768;
        endfunction

        function logic signed [ANGLE_W-1:0] predict_angle(logic [TIME_W-1:0] t);
            longint p, ph, s, prod, u, angle;
            p = (period_r == 0) ? 1 : period_r;
            ph = ((longint'(t) % p) << PH_BITS) / p;
            case (mode_r)
                MODE_SINE:   s = sine_level(ph);
                MODE_SQUARE: s = (ph * 1000 < (clamp_frac(duty_r) << PH_BITS)) ? 32767 : -32768;
                MODE_TRI: begin
                    if (ph < (longint'(1) << (PH_BITS - 1)))
                        s = cap_high(-32768 + ((ph << 17) >> PH_BITS));
                    else
                        s = cap_high(98304 - ((ph << 17) >> PH_BITS));
                end
                MODE_SAW:    s = -32768 + ((ph << 16) >> PH_BITS);
                MODE_TRAP:   s = trapezoid_level(ph);
                default:     s = 0;
            endcase
            prod = longint'(amp_r) * s;
            u = (prod + 16384 + (longint'(1) << 40)) >>> 15;
            angle = longint'(offset_r) + (u - (longint'(1) << 25));
            if (angle > 131071) angle = 131071;
            if (angle < -131072) angle = -131072;
            return angle[ANGLE_W-1:0];
        endfunction

        function void note_time(logic [TIME_W-1:0] t);
            expected_angles.push_back(predict_angle(t));
        endfunction

        function void report(string msg);
            $display("mismatch: %s", msg);
            mismatches++;
        endfunction

        function void check_angle(logic signed [ANGLE_W-1:0] got);
            logic signed [ANGLE_W-1:0] want;
            if (expected_angles.size() == 0) begin
                report($sformatf("angle %0d arrived with nothing expected", got));
                return;
            end
            want = expected_angles.pop_front();
            checked++;
            if (got !== want)
                report($sformatf("angle %0d, expected %0d (beat %0d)", got, want, checked));
        endfunction

        function int pending();
            return expected_angles.size();
        endfunction
    endclass

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_valid = 1'b0;
    logic                          o_stall;
    logic [TIME_W-1:0]             i_time_ms = '0;
    logic                          o_valid;
    logic                          i_stall = 1'b0;
    logic signed [ANGLE_W-1:0]     o_angle_centideg;
    logic                          i_cfg_valid = 1'b0;
    logic                          o_cfg_ready;
    logic [CFG_IDX_W-1:0]          i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]         i_cfg_data = '0;

    angle_scoreboard sb = new();

    // Idle percentages for the sender and receiver, and the long hold-off flag.
    int  tx_idle_pct = 0;
    int  rx_idle_pct = 0;
    bit  rx_holding  = 0;
    event hold_off_ev;
    int  items_sent  = 0;
    int  cfg_writes  = 0;

    periodic_waveform_angle_core #(
        .SINE_TABLE_DEPTH(TABLE_DEPTH),
        .PHASE_BITS      (PH_BITS)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_time_ms       (i_time_ms),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_angle_centideg(o_angle_centideg),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    // 12 ns clock.
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Receiver: random stalls, plus a long hold-off while the flag is up.
    always @(posedge i_clk) begin
        i_stall <= rx_holding || ($urandom_range(0, 99) < rx_idle_pct);
    end

    // The long hold-off is counted here so that the sender keeps offering beats
    // and the block fills up until it stalls its input.
    always begin
        @(hold_off_ev);
        rx_holding = 1;
        repeat (400) @(posedge i_clk);
        rx_holding = 0;
    end

    // Monitor: values are sampled at the edge, before any of this edge's updates.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) sb.note_time(i_time_ms);
            if (o_valid && !i_stall) sb.check_angle(o_angle_centideg);
        end
    end

    // Offer one time beat, with random idle cycles ahead of it, and hold it
    // until the block takes it. Valid stays high between back-to-back beats.
    task automatic send_time(logic [TIME_W-1:0] t);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_time_ms <= t;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        items_sent++;
    endtask

    // Wait until every predicted angle has come out, then let the pipeline settle.
    task automatic drain();
        int waited;
        waited = 0;
        i_valid <= 1'b0;
        while (sb.pending() != 0) begin
            @(posedge i_clk);
            waited++;
            if (waited > 200000) begin
                $display("timeout while draining, %0d angles outstanding", sb.pending());
                $display("FAIL");
                $finish;
            end
        end
        repeat (80) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] d);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.write_reg(idx, d);
        i_cfg_valid <= 1'b0;
        cfg_writes++;
    endtask

    // Offsets and amplitudes are 17-bit signed; the spare upper data bits are
    // filled with noise since the block ignores them.
    function automatic logic [CFG_DATA_W-1:0] angle_word(int v);
        logic [CFG_DATA_W-1:0] w;
        w = v[CFG_DATA_W-1:0];
        w[CFG_DATA_W-1:CFG_ANG_W] = (CFG_DATA_W - CFG_ANG_W)'($urandom());
        return w;
    endfunction

    task automatic apply_setting(int mode, int period, int duty, int rise, int hold,
                                 int fall, int offs, int amp);
        drain();
        write_cfg(CFG_SHAPE_MODE, CFG_DATA_W'({$urandom(), mode[MODE_W-1:0]}));
        write_cfg(CFG_PERIOD, period[CFG_DATA_W-1:0]);
        write_cfg(CFG_DUTY, CFG_DATA_W'({$urandom(), duty[FRAC_W-1:0]}));
        write_cfg(CFG_RISE, CFG_DATA_W'({$urandom(), rise[FRAC_W-1:0]}));
        write_cfg(CFG_HOLD, CFG_DATA_W'({$urandom(), hold[FRAC_W-1:0]}));
        write_cfg(CFG_FALL, CFG_DATA_W'({$urandom(), fall[FRAC_W-1:0]}));
        write_cfg(CFG_OFFSET, angle_word(offs));
        write_cfg(CFG_AMPLITUDE, angle_word(amp));
    endtask

    // A random time: mostly free-running values, sometimes right at a period edge.
    function automatic logic [TIME_W-1:0] pick_time(int period);
        int unsigned p, sel;
        p = (period == 0) ? 1 : period;
        sel = $urandom_range(0, 9);
        if (sel < 6) return $urandom();
        if (sel == 6) return p * $urandom_range(0, 200);
        if (sel == 7) return p * $urandom_range(1, 200) - 1;
        if (sel == 8) return $urandom_range(0, 2 * p);
        return {$urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0} ^ $urandom_range(0, 3);
    endfunction

    initial begin
        int mode, period, duty, rise, hold, fall, offs, amp;
        int rand_done, per_phase;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part with the reset settings: time extremes and period edges.
        send_time(32'd0);
        send_time(32'hFFFF_FFFF);
        send_time(32'd250);
        send_time(32'd500);
        send_time(32'd750);
        send_time(32'd999);
        send_time(32'd1000);

        // Every other shape, a zero period, full-scale period, duty and segment extremes,
        // an oversized trapezoid, zero-length segments, and the offset-only modes.
        apply_setting(MODE_SQUARE, 0, 1023, 0, 0, 0, 36000, -36000);
        send_time(32'd12345);
        send_time(32'hFFFF_FFFF);
        apply_setting(MODE_SQUARE, 1000, 0, 0, 0, 0, -36000, 36000);
        send_time(32'd0);
        send_time(32'd999);
        apply_setting(MODE_TRI, 16777215, 500, 0, 0, 0, -36000, -36000);
        send_time(32'd8388607);
        send_time(32'd8388608);
        send_time(32'd16777214);
        apply_setting(MODE_SAW, 1, 500, 0, 0, 0, 36000, 36000);
        send_time(32'd7);
        apply_setting(MODE_TRAP, 1000, 500, 1023, 1023, 1023, 0, 36000);
        send_time(32'd100);
        send_time(32'd500);
        send_time(32'd900);
        apply_setting(MODE_TRAP, 1000, 500, 0, 0, 0, 0, 36000);
        send_time(32'd0);
        send_time(32'd500);
        apply_setting(5, 777, 500, 250, 250, 250, -12345, 36000);
        send_time(32'd3);
        apply_setting(7, 777, 500, 250, 250, 250, 35999, 36000);
        send_time(32'd5);

        // Random part: a new setting every phase, shifting the idle pattern by thirds.
        rand_done = 0;
        while (rand_done < RAND_ITEMS) begin
            if (rand_done < RAND_ITEMS / 3) begin
                tx_idle_pct = 8; rx_idle_pct = 65;
            end else if (rand_done < 2 * RAND_ITEMS / 3) begin
                tx_idle_pct = 65; rx_idle_pct = 8;
            end else begin
                tx_idle_pct = 0; rx_idle_pct = 0;
            end
            mode = $urandom_range(0, 9);
            if (mode > 7) mode = $urandom_range(0, 4);
            case ($urandom_range(0, 5))
                0: period = $urandom_range(0, 3);
                1: period = 16777215 - $urandom_range(0, 3);
                2: period = $urandom_range(0, 16777215);
                default: period = $urandom_range(2, 5000);
            endcase
            duty = ($urandom_range(0, 3) == 0) ? $urandom_range(990, 1023) : $urandom_range(0, 1000);
            rise = $urandom_range(0, 4) == 0 ? 0 : $urandom_range(0, 1023);
            hold = $urandom_range(0, 4) == 0 ? 0 : $urandom_range(0, 700);
            fall = $urandom_range(0, 4) == 0 ? 0 : $urandom_range(0, 600);
            offs = $urandom_range(0, 72000) - 36000;
            amp  = $urandom_range(0, 72000) - 36000;
            if ($urandom_range(0, 7) == 0) offs = $urandom_range(0, 131071) - 65536;
            if ($urandom_range(0, 7) == 0) amp  = $urandom_range(0, 131071) - 65536;
            apply_setting(mode, period, duty, rise, hold, fall, offs, amp);
            per_phase = $urandom_range(20, 45);
            // One phase with no idling runs into a long receiver hold-off.
            if (rand_done >= 2 * RAND_ITEMS / 3 && rx_holding == 0 && per_phase > 0 &&
                (rand_done - 2 * RAND_ITEMS / 3) < 45) begin
                -> hold_off_ev;
                per_phase = 120;
            end
            for (int n = 0; n < per_phase; n++) begin
                send_time(pick_time(period));
                rand_done++;
            end
        end

        drain();
        $display("covered %0d time beats and %0d register writes across all shape modes,",
                 items_sent, cfg_writes);
        $display("with idle sender, idle receiver, back-to-back and a long output hold-off");
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Overall guard against a hung handshake.
    initial begin
        #200_000_000;
        $display("run exceeded its time budget");
        $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire
